>>> hw/rtl/srd_pkg.sv
// Shared types and constants for the run-length sprite decoder.
`default_nettype none

package srd_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int RUN_LIMIT = 2048;
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int ROW_CW    = ROW_AW + 1;
  localparam int POS_W     = 18;
  localparam int X_MAX     = 2047;
  localparam int Y_MAX     = 1023;
  localparam int HDR_WORDS = 4;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TABLE,
    PH_SEEK,
    PH_SKIP,
    PH_LEN,
    PH_PIXELS
  } phase_t;

  typedef struct packed {
    logic [15:0] blob_word;
    logic        blob_start;
  } blob_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [10:0] pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] pixel_colour;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sprite_rle_decoder.sv
// Top level: run-length sprite decoder with a two-word result buffer.
//
//   channel | valid     | stall     | word     | moves
//   blob    | src_valid | src_stall | src_word | one 16-bit blob word + start flag
//   result  | pix_valid | pix_stall | pix_word | pixel, done or error
//
// One blob word per cycle while src_stall is low; each word yields at most one result word.
// A result is offered the cycle after its blob word is taken, behind any
// results already waiting in the buffer.
// src_stall rises only when both buffer entries hold unread results.
// Reset (rst, synchronous) idles the parser; the offset table is not cleared.
// Row seeks use the table entry fetched ahead on the single memory read port.
`default_nettype none

module sprite_rle_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  srd_pkg::blob_t   src_word,
  output logic             pix_valid,
  input  logic             pix_stall,
  output srd_pkg::result_t pix_word
);
  import srd_pkg::*;

  logic    take, res_valid, push, pop;
  result_t res;
  result_t q [2];
  logic    head;
  logic [1:0] count;
  logic    tail;

  assign src_stall = (count == 2'd2);
  assign take      = src_valid && !src_stall;
  assign push      = take && res_valid;
  assign pop       = pix_valid && !pix_stall;
  assign pix_valid = (count != 2'd0);
  assign pix_word  = q[head];
  assign tail      = head ^ count[0];

  srd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (src_word),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) head <= ~head;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) q[tail] <= res;
  end

endmodule

`default_nettype wire

>>> hw/rtl/srd_core.sv
// Blob parser with the row offset table memory; one result per word at most.
`default_nettype none

module srd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  srd_pkg::blob_t  item,
  output logic            res_valid,
  output srd_pkg::result_t res
);
  import srd_pkg::*;

  phase_t              phase, phase_next, ph;
  logic [POS_W-1:0]    pos, pos_next, p;
  logic [15:0]         width, width_next;
  logic [ROW_CW-1:0]   height, height_next;
  logic [ROW_CW-1:0]   row, row_next, row_inc;
  logic [15:0]         col, col_next;
  logic [15:0]         remain, remain_next, remain_dec;
  logic [15:0]         skip, skip_next;
  logic [POS_W-1:0]    tend, tend_next;

  logic [15:0]         mem [MAX_ROWS];
  logic [15:0]         rd_q, byp_data, rd_data;
  logic                byp_hit;
  logic                wr_en;
  logic [ROW_AW-1:0]   wr_addr, rd_addr;
  logic [POS_W:0]      tbl_off;

  logic [15:0]         w;
  logic [POS_W-1:0]    target;
  logic [16:0]         sum;
  logic                hdr_w, hdr_h, h_zero, h_big, tbl_last;
  logic                seek_wait, seek_late, run_end, last_row, len_zero, pix_last, pix_in;

  // Start word overrides the phase and position.
  always_comb begin
    ph = item.blob_start ? PH_HEADER : phase;
    p  = item.blob_start ? '0 : pos;
    w  = item.blob_word;
  end

  always_comb begin
    hdr_w      = (p == POS_W'(2));
    hdr_h      = (p == POS_W'(3));
    h_zero     = (w == 16'd0);
    h_big      = (32'(w) > MAX_ROWS);
    tbl_last   = ({1'b0, p} + (POS_W+1)'(1)) >= {1'b0, tend};
    target     = tend + POS_W'(rd_data);
    seek_wait  = (p < target);
    seek_late  = (p > target);
    sum        = {1'b0, skip} + {1'b0, w};
    run_end    = (32'(sum) >= RUN_LIMIT) || (sum == 17'd0);
    row_inc    = row + ROW_CW'(1);
    last_row   = (row_inc >= height);
    len_zero   = (w == 16'd0);
    remain_dec = remain - 16'd1;
    pix_last   = (remain_dec == 16'd0);
    pix_in     = (col < width) && (32'(col) <= X_MAX) && (32'(row) <= Y_MAX);
    tbl_off    = {1'b0, p} - (POS_W+1)'(HDR_WORDS);
    wr_en      = take && (ph == PH_TABLE) && !tbl_off[POS_W]
                 && (32'(tbl_off[POS_W-1:0]) < MAX_ROWS);
    wr_addr    = tbl_off[ROW_AW-1:0];
  end

  // Next state.
  always_comb begin
    phase_next = phase;
    if (take) begin
      case (ph)
        PH_IDLE: phase_next = PH_IDLE;
        PH_HEADER: begin
          if (hdr_h) begin
            if (h_zero || h_big) phase_next = PH_IDLE;
            else                 phase_next = PH_TABLE;
          end else begin
            phase_next = PH_HEADER;
          end
        end
        PH_TABLE: phase_next = tbl_last ? PH_SEEK : PH_TABLE;
        PH_SEEK: begin
          if (seek_wait)      phase_next = PH_SEEK;
          else if (seek_late) phase_next = PH_IDLE;
          else                phase_next = PH_LEN;
        end
        PH_SKIP: phase_next = PH_LEN;
        PH_LEN: begin
          if (run_end)       phase_next = last_row ? PH_IDLE : PH_SEEK;
          else if (len_zero) phase_next = PH_SKIP;
          else               phase_next = PH_PIXELS;
        end
        PH_PIXELS: phase_next = pix_last ? PH_SKIP : PH_PIXELS;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // Datapath and result.
  always_comb begin
    pos_next    = pos;
    width_next  = width;
    height_next = height;
    row_next    = row;
    col_next    = col;
    remain_next = remain;
    skip_next   = skip;
    tend_next   = tend;
    res_valid   = 1'b0;
    res         = '0;
    if (take && ph != PH_IDLE) begin
      pos_next = (p < POS_MAX) ? p + POS_W'(1) : p;
    end
    if (take) begin
      case (ph)
        PH_HEADER: begin
          if (hdr_w) width_next = w;
          if (hdr_h) begin
            height_next = w[ROW_CW-1:0];
            row_next    = '0;
            tend_next   = POS_W'(HDR_WORDS) + POS_W'(w);
            if (h_zero) begin
              res_valid       = 1'b1;
              res.result_kind = KIND_DONE;
            end else if (h_big) begin
              res_valid       = 1'b1;
              res.result_kind = KIND_ERROR;
            end
          end
        end
        PH_SEEK: begin
          if (!seek_wait && seek_late) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_ERROR;
          end else if (!seek_wait) begin
            col_next  = '0;
            skip_next = w;
          end
        end
        PH_SKIP: skip_next = w;
        PH_LEN: begin
          col_next = col + skip;
          if (run_end) begin
            row_next = row_inc;
            if (last_row) begin
              res_valid       = 1'b1;
              res.result_kind = KIND_DONE;
            end
          end else if (!len_zero) begin
            remain_next = w;
          end
        end
        PH_PIXELS: begin
          if (pix_in) begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_PIXEL;
            res.pixel_x      = col[10:0];
            res.pixel_y      = row[9:0];
            res.pixel_colour = w;
          end
          col_next    = col + 16'd1;
          remain_next = remain_dec;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      pos    <= '0;
      width  <= '0;
      height <= '0;
      row    <= '0;
      col    <= '0;
      remain <= '0;
      skip   <= '0;
      tend   <= '0;
    end else begin
      phase  <= phase_next;
      pos    <= pos_next;
      width  <= width_next;
      height <= height_next;
      row    <= row_next;
      col    <= col_next;
      remain <= remain_next;
      skip   <= skip_next;
      tend   <= tend_next;
    end
  end

  // Offset table: read address follows the next row, so the entry is ready
  // when the row's seek begins. Same-entry write forwards through a bypass.
  assign rd_addr = row_next[ROW_AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= w;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= wr_en && (wr_addr == rd_addr);
    end
    byp_data <= w;
  end

  assign rd_data = byp_hit ? byp_data : rd_q;

  a_res_needs_take: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> take) else $error("result without accepted word");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.result_kind != KIND_PIXEL) |=> phase == PH_IDLE)
    else $error("done or error did not stop parsing");

  a_pixel_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.result_kind == KIND_PIXEL) |-> (phase == PH_PIXELS && !item.blob_start))
    else $error("pixel outside pixel phase");

  a_seek_row: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SEEK) |-> (row < height))
    else $error("seek past last row");

endmodule

`default_nettype wire

>>> dv/sprite_rle_decoder_tb.sv
// Self-checking testbench for sprite_rle_decoder: blob words in, checked result words out.
module sprite_rle_decoder_tb;
  import srd_pkg::*;

  localparam int RANDOM_WORDS = 760;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 16;
  localparam int TALL_EXTRA   = 40;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    src_valid = 1'b0;
  blob_t   src_word  = '0;
  logic    pix_stall = 1'b0;
  logic    src_stall;
  logic    pix_valid;
  result_t pix_word;

  sprite_rle_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_word  (pix_word)
  );

  always #4 clk = ~clk;

  // decoder state mirror
  phase_t      parse_ph;
  logic [17:0] word_pos;
  logic [15:0] row_offsets [0:MAX_ROWS-1];
  logic [15:0] img_width, img_height, row_idx, col, run_left, skip_word;
  logic [17:0] table_end;

  result_t     decoded_words [$];
  logic [15:0] sprite_words [$];

  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  int hold_left     = 0;
  int hold_draw;
  int quiet_cycles  = 0;
  int fail_count    = 0;
  int words_in      = 0;
  int pixel_count   = 0;
  int done_count    = 0;
  int reject_count  = 0;

  function automatic void emit_result(logic [1:0] kind, logic [10:0] x, logic [9:0] y,
                                      logic [15:0] colour);
    result_t r;
    r.result_kind  = kind;
    r.pixel_x      = x;
    r.pixel_y      = y;
    r.pixel_colour = colour;
    decoded_words.push_back(r);
  endfunction

  function automatic void decode_word(blob_t item);
    logic [17:0] at;
    logic [17:0] target;
    logic [16:0] run_sum;
    logic [15:0] d;
    d = item.blob_word;
    if (item.blob_start) begin
      parse_ph = PH_HEADER;
      word_pos = '0;
    end
    if (parse_ph == PH_IDLE) return;
    at = word_pos;
    if (word_pos != POS_MAX) word_pos = word_pos + 18'd1;
    case (parse_ph)
      PH_HEADER: begin
        if (at == 18'd2) begin
          img_width = d;
        end else if (at == 18'd3) begin
          img_height = d;
          row_idx = '0;
          table_end = 18'(HDR_WORDS) + 18'(d);
          if (d == 16'd0) begin
            parse_ph = PH_IDLE;
            emit_result(KIND_DONE, '0, '0, '0);
          end else if (32'(d) > MAX_ROWS) begin
            parse_ph = PH_IDLE;
            emit_result(KIND_ERROR, '0, '0, '0);
          end else begin
            parse_ph = PH_TABLE;
          end
        end
      end
      PH_TABLE: begin
        if (32'(at) >= HDR_WORDS && 32'(at - 18'(HDR_WORDS)) < MAX_ROWS)
          row_offsets[ROW_AW'(at - 18'(HDR_WORDS))] = d;
        if ((at + 18'd1) >= table_end) parse_ph = PH_SEEK;
      end
      PH_SEEK: begin
        target = table_end;
        if (32'(row_idx) < MAX_ROWS)
          target = table_end + 18'(row_offsets[row_idx[ROW_AW-1:0]]);
        if (at > target) begin
          parse_ph = PH_IDLE;
          emit_result(KIND_ERROR, '0, '0, '0);
        end else if (at == target) begin
          col = '0;
          skip_word = d;
          parse_ph = PH_LEN;
        end
      end
      PH_SKIP: begin
        skip_word = d;
        parse_ph = PH_LEN;
      end
      PH_LEN: begin
        run_sum = {1'b0, skip_word} + {1'b0, d};
        col = col + skip_word;
        if (32'(run_sum) >= RUN_LIMIT || run_sum == 17'd0) begin
          row_idx = row_idx + 16'd1;
          if (row_idx >= img_height) begin
            parse_ph = PH_IDLE;
            emit_result(KIND_DONE, '0, '0, '0);
          end else begin
            parse_ph = PH_SEEK;
          end
        end else if (d == 16'd0) begin
          parse_ph = PH_SKIP;
        end else begin
          run_left = d;
          parse_ph = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (col < img_width && 32'(col) <= X_MAX && 32'(row_idx) <= Y_MAX)
          emit_result(KIND_PIXEL, col[10:0], row_idx[9:0], d);
        col = col + 16'd1;
        run_left = run_left - 16'd1;
        if (run_left == 16'd0) parse_ph = PH_SKIP;
      end
      default: parse_ph = PH_IDLE;
    endcase
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function automatic void check_result(result_t got);
    result_t want;
    case (got.result_kind)
      KIND_PIXEL: pixel_count++;
      KIND_DONE:  done_count++;
      default:    reject_count++;
    endcase
    if (decoded_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t unexpected word: expected none, actual kind=%0d x=%0d y=%0d colour=%h",
                 $time, got.result_kind, got.pixel_x, got.pixel_y, got.pixel_colour);
      return;
    end
    want = decoded_words.pop_front();
    compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    compare_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
    compare_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
    compare_field("pixel_colour", 32'(want.pixel_colour), 32'(got.pixel_colour));
  endfunction

  // results are checked before the word taken at the same edge is decoded
  always @(posedge clk) begin
    if (rst) begin
      parse_ph   = PH_IDLE;
      word_pos   = '0;
      img_width  = '0;
      img_height = '0;
      row_idx    = '0;
      col        = '0;
      run_left   = '0;
      skip_word  = '0;
      table_end  = '0;
    end else begin
      if (pix_valid && !pix_stall) check_result(pix_word);
      if (src_valid && !src_stall) begin
        words_in++;
        decode_word(src_word);
      end
      if ((pix_valid && !pix_stall) || (src_valid && !src_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t no word moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, decoded_words.size());
        $display("sprite_rle_decoder verification failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pix_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pix_stall <= (hold_left > 1);
    end else if (pix_valid && !pix_stall) begin
      hold_draw = receiver_idle ? $urandom_range(0, 6) : 0;
      hold_left <= hold_draw;
      pix_stall <= (hold_draw > 0);
    end
  end

  task automatic send_word(input logic [15:0] data, input logic start);
    int gap;
    gap = sender_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word  <= '{blob_word: data, blob_start: start};
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  task automatic send_blob(input int count);
    for (int i = 0; i < count; i++) send_word(sprite_words[i], i == 0);
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    @(posedge clk);
    while (decoded_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  // sparse: only a few rows carry pixels; spoil: one row offset points backward
  task automatic build_sprite(input logic [15:0] width, input int rows, input bit sparse,
                              input bit spoil);
    logic [15:0] body [$];
    int          offs [$];
    logic [15:0] skip, len;
    int          gap, runs, bad_row;
    bad_row = (spoil && rows > 1) ? $urandom_range(1, rows - 1) : -1;
    for (int r = 0; r < rows; r++) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (gap) body.push_back(16'($urandom_range(0, 65535)));
      if (r == bad_row) offs.push_back(body.size() - gap - $urandom_range(1, 2));
      else offs.push_back(body.size());
      if (sparse) runs = (r % 97 == 0 || r == rows - 1) ? 1 : 0;
      else runs = $urandom_range(0, 3);
      repeat (runs) begin
        case ($urandom_range(0, 7))
          0: begin
            skip = 16'($urandom_range(1, 8));
            len  = 0;
          end
          1: begin
            skip = 16'($urandom_range(900, 2040));
            len  = 16'($urandom_range(1, 6));
          end
          default: begin
            skip = 16'($urandom_range(0, 8));
            len  = 16'($urandom_range(1, 6));
          end
        endcase
        body.push_back(skip);
        body.push_back(len);
        repeat (len) body.push_back(16'($urandom_range(0, 65535)));
      end
      // row terminator: zero run or skip+len at or past the run limit
      case ($urandom_range(0, 3))
        0, 1: begin
          skip = 0;
          len  = 0;
        end
        2: begin
          skip = 16'($urandom_range(0, 2047));
          len  = 16'(RUN_LIMIT - skip + $urandom_range(0, 3));
        end
        default: begin
          skip = 16'($urandom_range(RUN_LIMIT, 65535));
          len  = 16'($urandom_range(0, 65535));
        end
      endcase
      body.push_back(skip);
      body.push_back(len);
    end
    sprite_words = {};
    sprite_words.push_back(16'($urandom_range(0, 65535)));
    sprite_words.push_back(16'($urandom_range(0, 65535)));
    sprite_words.push_back(width);
    sprite_words.push_back(16'(rows));
    foreach (offs[i]) sprite_words.push_back(16'(offs[i]));
    foreach (body[i]) sprite_words.push_back(body[i]);
  endtask

  // two rows: zero-length run, pixel past width, run-limit row end, then backward offset
  task automatic test_row_parsing();
    sprite_words = {16'hFFFF, 16'h0000, 16'h0002, 16'h0002, 16'h0000, 16'h0003,
                    16'h0001, 16'h0000, 16'h0000, 16'h0002, 16'hFFFF, 16'h0000,
                    16'h07FF, 16'h0001, 16'h5555};
    send_blob(sprite_words.size());
    send_word(16'hFFFF, 1'b0);
  endtask

  task automatic test_restart_and_empty();
    sprite_words = {16'h0000, 16'h0000, 16'hFFFF};
    send_blob(sprite_words.size());
    sprite_words = {16'h0001, 16'h0001, 16'h0001, 16'h0000};
    send_blob(sprite_words.size());
  endtask

  task automatic test_oversize_height();
    sprite_words = {16'hFFFF, 16'hFFFF, 16'h0010, 16'(MAX_ROWS + 1)};
    send_blob(sprite_words.size());
  endtask

  // full offset table at the largest height, then the first rows only
  task automatic test_tallest_sprite();
    build_sprite(16'hFFFF, MAX_ROWS, 1'b1, 1'b0);
    send_blob(HDR_WORDS + MAX_ROWS + TALL_EXTRA);
    wait_drained();
  endtask

  task automatic test_random_sprites();
    int sent, rounds, shape, cut;
    sent = 0;
    rounds = 0;
    while (sent < RANDOM_WORDS) begin
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      shape = $urandom_range(0, 19);
      case (shape)
        0: begin
          repeat ($urandom_range(1, 8))
            send_word(16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
        end
        1: begin
          build_sprite(pick_width(), $urandom_range(1, 6), 1'b0, 1'b0);
          cut = $urandom_range(1, sprite_words.size());
          send_blob(cut);
          sent += cut;
        end
        2: begin
          build_sprite(pick_width(), 0, 1'b0, 1'b0);
          sprite_words[3] = 16'($urandom_range(MAX_ROWS + 1, 65535));
          send_blob(sprite_words.size());
          sent += sprite_words.size();
        end
        3: begin
          build_sprite(pick_width(), $urandom_range(2, 6), 1'b0, 1'b1);
          send_blob(sprite_words.size());
          sent += sprite_words.size();
        end
        4: begin
          build_sprite(pick_width(), 0, 1'b0, 1'b0);
          send_blob(sprite_words.size());
          sent += sprite_words.size();
        end
        default: begin
          build_sprite(pick_width(), $urandom_range(1, 6), 1'b0, 1'b0);
          send_blob(sprite_words.size());
          sent += sprite_words.size();
        end
      endcase
      rounds++;
      if (rounds % 8 == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_row_parsing();
    test_restart_and_empty();
    test_oversize_height();
    test_tallest_sprite();
    test_random_sprites();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("fed %0d blob words: directed header/row cases, a full-height table, random sprites",
             words_in);
    $display("checked %0d pixels, %0d finished images, %0d rejected blobs",
             pixel_count, done_count, reject_count);
    if (fail_count == 0 && decoded_words.size() == 0) begin
      $display("sprite_rle_decoder verification clean");
    end else begin
      $display("sprite_rle_decoder verification failed");
    end
    $finish;
  end

endmodule
